// ===== src/rct_pkg.sv =====
// ----------------------------------------------------------------------------
// rct_pkg
// Shared types and constants for the residue contact test block.
// ----------------------------------------------------------------------------
package rct_pkg;

    localparam int DEF_MAX_RESIDUES = 1024;
    localparam int DEF_MAX_ATOMS    = 16;

    localparam int COORD_BITS  = 20;
    localparam int DIFF_W      = COORD_BITS + 1;
    localparam int MAG_W       = COORD_BITS + 1;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int SUM_W       = SQ_W + 2;
    localparam int CUT_W       = 19;
    localparam int CUTSQ_W     = 2 * CUT_W;
    localparam int SEP_W       = 10;
    localparam int RES_FIELD_W = 10;
    localparam int NUM_AXES    = 3;

    localparam logic [1:0] MODE_ANY   = 2'd0;
    localparam logic [1:0] MODE_ALPHA = 2'd1;
    localparam logic [1:0] MODE_BETA  = 2'd2;

    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_CUT_ANY  = 3'd1;
    localparam logic [2:0] REG_CUT_CA   = 3'd2;
    localparam logic [2:0] REG_CUT_CB   = 3'd3;
    localparam logic [2:0] REG_MIN_SEP  = 3'd4;

    localparam logic [0:0] KIND_LOAD  = 1'b0;
    localparam logic [0:0] KIND_QUERY = 1'b1;

    // drain count covers the distance chain after the read register; margin included
    localparam logic [3:0] DRAIN_CYC = 4'd12;

    typedef struct packed {
        logic [1:0]                           kind;
        logic [NUM_AXES-1:0][COORD_BITS-1:0]  xyz;
    } atom_t;

    typedef struct packed {
        logic                                 vld;
        logic [NUM_AXES-1:0][COORD_BITS-1:0]  p;
        logic [NUM_AXES-1:0][COORD_BITS-1:0]  q;
        logic [SUM_W-1:0]                     sum;
        logic                                 far;
    } cell_pkt_t;

endpackage

// ===== src/residue_contact_test_top.sv =====
// ----------------------------------------------------------------------------
// residue_contact_test_top
// Per-residue atom store with a residue pair contact test.
// ----------------------------------------------------------------------------
// channel   dir  payload
// s_*       in   tuser kind; tdata residue/slot/atom kind/x/y/z
// m_*       out  tuser is_query_answer; tdata in_contact
// cfg_*     in   register index and write data
//
// Any-atom query: one pair per cycle through the chain. Alpha/beta query:
// slot scan, then one pair. After reset a count clearing pass over all
// MAX_RESIDUES entries runs with s_tready low. A stalled m_* holds the
// block in ST_DONE.
// ----------------------------------------------------------------------------
module residue_contact_test_top
    import rct_pkg::*;
#(
    parameter int MAX_RESIDUES = DEF_MAX_RESIDUES,
    parameter int MAX_ATOMS    = DEF_MAX_ATOMS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // residue_a, residue_b, atom_slot, atom_kind, coord_x, coord_y, coord_z
    input  logic [87:0] s_tdata,
    // kind
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // in_contact
    output logic [7:0]  m_tdata,
    // is_query_answer
    output logic        m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [18:0] cfg_data
);

    localparam int RES_W  = $clog2(MAX_RESIDUES);
    localparam int SLOT_W = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CNT_W  = $clog2(MAX_ATOMS + 1);
    localparam int SLOTS  = MAX_RESIDUES * MAX_ATOMS;
    localparam int ADDR_W = $clog2(SLOTS);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_QCNT, ST_PAIR, ST_SCAN,
        ST_SCANW, ST_FEED, ST_DRAIN, ST_DONE
    } state_t;

    // input fields
    logic [RES_FIELD_W-1:0] in_ra, in_rb;
    logic [3:0]             in_slot;
    logic [1:0]             in_akind;
    atom_t                  in_atom;
    logic                   accept, load_ok;

    assign in_ra    = s_tdata[9:0];
    assign in_rb    = s_tdata[19:10];
    assign in_slot  = s_tdata[23:20];
    assign in_akind = s_tdata[25:24];
    assign in_atom.kind   = in_akind;
    assign in_atom.xyz[0] = s_tdata[45:26];
    assign in_atom.xyz[1] = s_tdata[65:46];
    assign in_atom.xyz[2] = s_tdata[85:66];

    // configuration
    logic [1:0]       mode_reg;
    logic [CUT_W-1:0] cut_any_reg, cut_ca_reg, cut_cb_reg;
    logic [SEP_W-1:0] min_sep_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_ANY;
            cut_any_reg <= CUT_W'(1152);
            cut_ca_reg  <= CUT_W'(2048);
            cut_cb_reg  <= CUT_W'(2048);
            min_sep_reg <= SEP_W'(3);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MODE:    mode_reg    <= cfg_data[1:0];
                REG_CUT_ANY: cut_any_reg <= cfg_data;
                REG_CUT_CA:  cut_ca_reg  <= cfg_data;
                REG_CUT_CB:  cut_cb_reg  <= cfg_data;
                REG_MIN_SEP: min_sep_reg <= cfg_data[SEP_W-1:0];
                default: ;
            endcase
        end
    end

    // control state
    state_t             state_reg;
    logic [RES_W-1:0]   clr_reg;
    logic [RES_W-1:0]   qa_reg, qb_reg;
    logic               qok_reg, qkind_reg;
    logic [CNT_W-1:0]   cnt_a_reg, cnt_b_reg;
    logic [SLOT_W-1:0]  i_reg, j_reg;
    logic [3:0]         drain_reg;
    logic               hit_reg;
    logic               found_a_reg, found_b_reg;
    logic [NUM_AXES-1:0][COORD_BITS-1:0] cap_a_reg, cap_b_reg;
    logic               m_tvalid_reg, m_contact_reg, m_query_reg;

    // memories
    atom_t              atom_mem [SLOTS];
    logic [CNT_W-1:0]   cnt_mem  [MAX_RESIDUES];
    atom_t              rd_a_reg, rd_b_reg;
    logic               rd_pair_vld_reg, rd_scan_vld_reg, rd_ina_reg, rd_inb_reg;

    logic [ADDR_W-1:0]  addr_a, addr_b, addr_w;
    logic [CNT_W-1:0]   cnt_max;
    logic               out_free, q_ok;
    logic [RES_FIELD_W:0] sep_lim;
    logic [CUT_W-1:0]   cut_sel;
    cell_pkt_t          chain_in;
    logic               hit_vld, hit;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load_ok  = (int'(in_ra) < MAX_RESIDUES) && (int'(in_slot) < MAX_ATOMS);
    assign sep_lim  = {1'b0, in_ra} + {1'b0, min_sep_reg};
    assign q_ok     = (int'(in_ra) < MAX_RESIDUES) && (int'(in_rb) < MAX_RESIDUES)
                   && ({1'b0, in_rb} >= sep_lim);
    assign out_free = !m_tvalid_reg || m_tready;
    assign cnt_max  = (cnt_a_reg > cnt_b_reg) ? cnt_a_reg : cnt_b_reg;

    assign addr_w = ADDR_W'(RES_W'(in_ra)) * ADDR_W'(MAX_ATOMS) + ADDR_W'(in_slot);
    assign addr_a = ADDR_W'(qa_reg) * ADDR_W'(MAX_ATOMS) + ADDR_W'(i_reg);
    assign addr_b = ADDR_W'(qb_reg) * ADDR_W'(MAX_ATOMS) + ADDR_W'(j_reg);

    always_ff @(posedge aclk) begin
        if (accept && s_tuser == KIND_LOAD && load_ok) begin
            atom_mem[addr_w] <= in_atom;
        end
        rd_a_reg <= atom_mem[addr_a];
        rd_b_reg <= atom_mem[addr_b];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            cnt_mem[clr_reg] <= '0;
        end else if (accept && s_tuser == KIND_LOAD && load_ok) begin
            cnt_mem[RES_W'(in_ra)] <= CNT_W'(5'(in_slot) + 5'd1);
        end
        if (accept) begin
            cnt_a_reg <= cnt_mem[RES_W'(in_ra)];
            cnt_b_reg <= cnt_mem[RES_W'(in_rb)];
        end
    end

    always_comb begin
        case (mode_reg)
            MODE_ALPHA: cut_sel = cut_ca_reg;
            MODE_BETA:  cut_sel = cut_cb_reg;
            default:    cut_sel = cut_any_reg;
        endcase
        chain_in.vld = rd_pair_vld_reg
                    || (state_reg == ST_FEED && found_a_reg && found_b_reg);
        chain_in.p   = rd_pair_vld_reg ? rd_a_reg.xyz : cap_a_reg;
        chain_in.q   = rd_pair_vld_reg ? rd_b_reg.xyz : cap_b_reg;
        chain_in.sum = '0;
        chain_in.far = 1'b0;
    end

    rct_dist_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cut     (cut_sel),
        .pkt_i   (chain_in),
        .hit_vld (hit_vld),
        .hit     (hit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
            rd_pair_vld_reg <= 1'b0;
            rd_scan_vld_reg <= 1'b0;
            hit_reg         <= 1'b0;
            found_a_reg     <= 1'b0;
            found_b_reg     <= 1'b0;
        end else begin
            rd_pair_vld_reg <= (state_reg == ST_PAIR);
            rd_scan_vld_reg <= (state_reg == ST_SCAN);
            rd_ina_reg      <= CNT_W'(i_reg) < cnt_a_reg;
            rd_inb_reg      <= CNT_W'(j_reg) < cnt_b_reg;
            if (hit_vld && hit) begin
                hit_reg <= 1'b1;
            end
            if (rd_scan_vld_reg) begin
                if (rd_ina_reg && !found_a_reg && rd_a_reg.kind == mode_reg) begin
                    found_a_reg <= 1'b1;
                    cap_a_reg   <= rd_a_reg.xyz;
                end
                if (rd_inb_reg && !found_b_reg && rd_b_reg.kind == mode_reg) begin
                    found_b_reg <= 1'b1;
                    cap_b_reg   <= rd_b_reg.xyz;
                end
            end
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + RES_W'(1);
                    if (int'(clr_reg) == MAX_RESIDUES - 1) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        qa_reg      <= RES_W'(in_ra);
                        qb_reg      <= RES_W'(in_rb);
                        qok_reg     <= q_ok;
                        qkind_reg   <= s_tuser;
                        hit_reg     <= 1'b0;
                        found_a_reg <= 1'b0;
                        found_b_reg <= 1'b0;
                        i_reg       <= '0;
                        j_reg       <= '0;
                        state_reg   <= (s_tuser == KIND_QUERY) ? ST_QCNT : ST_DONE;
                    end
                end
                ST_QCNT: begin
                    if (!qok_reg) begin
                        state_reg <= ST_DONE;
                    end else begin
                        case (mode_reg)
                            MODE_ANY: begin
                                state_reg <= (cnt_a_reg == '0 || cnt_b_reg == '0)
                                           ? ST_DONE : ST_PAIR;
                            end
                            MODE_ALPHA, MODE_BETA: begin
                                state_reg <= (cnt_max == '0) ? ST_DONE : ST_SCAN;
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_PAIR: begin
                    if (CNT_W'(j_reg) + CNT_W'(1) == cnt_b_reg) begin
                        j_reg <= '0;
                        if (CNT_W'(i_reg) + CNT_W'(1) == cnt_a_reg) begin
                            drain_reg <= DRAIN_CYC;
                            state_reg <= ST_DRAIN;
                        end else begin
                            i_reg <= i_reg + SLOT_W'(1);
                        end
                    end else begin
                        j_reg <= j_reg + SLOT_W'(1);
                    end
                end
                ST_SCAN: begin
                    if (CNT_W'(i_reg) + CNT_W'(1) == cnt_max) begin
                        state_reg <= ST_SCANW;
                    end else begin
                        i_reg <= i_reg + SLOT_W'(1);
                        j_reg <= j_reg + SLOT_W'(1);
                    end
                end
                ST_SCANW: begin
                    state_reg <= ST_FEED;
                end
                ST_FEED: begin
                    drain_reg <= DRAIN_CYC;
                    state_reg <= ST_DRAIN;
                end
                ST_DRAIN: begin
                    drain_reg <= drain_reg - 4'd1;
                    if (drain_reg == 4'd0) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg  <= 1'b1;
                        m_contact_reg <= hit_reg && (qkind_reg == KIND_QUERY);
                        m_query_reg   <= (qkind_reg == KIND_QUERY);
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_contact_reg};
    assign m_tuser  = m_query_reg;

endmodule

// ===== src/rct_axis_cell.sv =====
// ----------------------------------------------------------------------------
// rct_axis_cell
// One cell of the distance chain: folds the square of one axis difference
// into the running sum and flags an axis gap above the cutoff.
// ----------------------------------------------------------------------------
module rct_axis_cell
    import rct_pkg::*;
#(
    parameter int AXIS = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CUT_W-1:0] cut,
    input  cell_pkt_t        pkt_i,
    output cell_pkt_t        pkt_o
);

    cell_pkt_t        s1_reg;
    logic [MAG_W-1:0] mag_reg;
    cell_pkt_t        out_reg;

    logic [DIFF_W-1:0] diff;
    logic [MAG_W-1:0]  mag;
    logic [SQ_W-1:0]   sq;

    always_comb begin
        diff = {pkt_i.p[AXIS][COORD_BITS-1], pkt_i.p[AXIS]}
             - {pkt_i.q[AXIS][COORD_BITS-1], pkt_i.q[AXIS]};
        mag  = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
        sq   = SQ_W'(mag_reg) * SQ_W'(mag_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.vld  <= 1'b0;
            out_reg.vld <= 1'b0;
        end else begin
            s1_reg.vld  <= pkt_i.vld;
            out_reg.vld <= s1_reg.vld;
        end
        s1_reg.p   <= pkt_i.p;
        s1_reg.q   <= pkt_i.q;
        s1_reg.sum <= pkt_i.sum;
        s1_reg.far <= pkt_i.far | (mag > MAG_W'(cut));
        mag_reg    <= mag;
        out_reg.p   <= s1_reg.p;
        out_reg.q   <= s1_reg.q;
        out_reg.far <= s1_reg.far;
        out_reg.sum <= s1_reg.sum + SUM_W'(sq);
    end

    assign pkt_o = out_reg;

endmodule

// ===== src/rct_dist_chain.sv =====
// ----------------------------------------------------------------------------
// rct_dist_chain
// Row of three axis cells and a final cutoff compare; one atom pair
// enters per cycle.
// ----------------------------------------------------------------------------
module rct_dist_chain
    import rct_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CUT_W-1:0] cut,
    input  cell_pkt_t        pkt_i,
    output logic             hit_vld,
    output logic             hit
);

    cell_pkt_t              link [NUM_AXES+1];
    logic [CUTSQ_W-1:0]     cut_sq_reg;
    logic                   hit_vld_reg;
    logic                   hit_reg;

    assign link[0] = pkt_i;

    for (genvar k = 0; k < NUM_AXES; k++) begin : g_cell
        rct_axis_cell #(.AXIS(k)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cut     (cut),
            .pkt_i   (link[k]),
            .pkt_o   (link[k+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_vld_reg <= 1'b0;
        end else begin
            hit_vld_reg <= link[NUM_AXES].vld;
        end
        cut_sq_reg <= CUTSQ_W'(cut) * CUTSQ_W'(cut);
        hit_reg    <= !link[NUM_AXES].far
                   && (link[NUM_AXES].sum <= SUM_W'(cut_sq_reg));
    end

    assign hit_vld = hit_vld_reg;
    assign hit     = hit_reg;

endmodule
